/* hw/rtl/twojm_pkg.sv */
// Shared types, constants and functions for the three-wheel joystick mixer.
// Holds the CORDIC and square-root step functions and the sine table.
// No dependencies.
`timescale 1ns / 1ps

package twojm_pkg;

   localparam int XY_W            = 41;
   localparam int Z_W             = 32;
   localparam int RAD_W           = 18;
   localparam int ROOT_W          = 9;
   localparam int HEAD_W          = 10;
   localparam int SPEED_W         = 12;
   localparam int BIAS_W          = 11;
   localparam int CORDIC_STEPS    = 31;
   localparam int STEPS_PER_STAGE = 2;
   localparam int CORDIC_STAGES   = (CORDIC_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int SIN_ENTRIES     = 181;

   localparam logic signed [HEAD_W-1:0] CENTRE      = 10'sd110;
   localparam logic [15:0]              HEAD_SCALE  = 16'd57294;
   // 1000 * 2^30 - 1000: turns the floor of the scaled angle into a ceiling
   localparam logic [47:0]              HEAD_BIAS   = 48'd1073741823000;
   localparam logic [18:0]              RECIP_1000  = 19'd268436;
   localparam int                       RECIP_1000_SH = 28;
   localparam logic [19:0]              RECIP_100   = 20'd671089;
   localparam int                       RECIP_100_SH  = 26;
   localparam logic [8:0]               HEAD_RIGHT  = 9'd90;

   localparam logic signed [HEAD_W-1:0] OFFSET_LEFT  = -10'sd60;
   localparam logic signed [HEAD_W-1:0] OFFSET_RIGHT = 10'sd60;
   localparam logic signed [HEAD_W-1:0] OFFSET_BACK  = 10'sd180;

   localparam logic [63:0] ONE_Q30     = 64'd1073741824;
   localparam logic [63:0] PI_Q30      = 64'd3373259426;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam logic signed [Z_W-1:0] ATAN_STEPS [10] = '{
      32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159, 32'sd67021687,
      32'sd33543516,  32'sd16775851,  32'sd8388437,   32'sd4194283,   32'sd2097149
   };

   typedef struct packed {
      logic                    valid;
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [Z_W-1:0]   z;
      logic [RAD_W-1:0]        rad;
      logic [ROOT_W-1:0]       root;
      logic                    neg;
      logic                    centre;
   } cordic_type;

   typedef logic [31:0] sin_word_type;
   typedef sin_word_type sin_rom_type [SIN_ENTRIES];

   function automatic logic signed [XY_W-1:0] shr_tz(input logic signed [XY_W-1:0] v,
                                                      input int s);
      logic signed [XY_W-1:0] r;
      if (v[XY_W-1]) begin
         r = -((-v) >>> s);
      end else begin
         r = v >>> s;
      end
      return r;
   endfunction

   function automatic cordic_type cordic_step(input cordic_type c, input int i);
      cordic_type             r;
      logic signed [XY_W-1:0] xs;
      logic signed [XY_W-1:0] ys;
      logic signed [Z_W-1:0]  st;
      r  = c;
      xs = shr_tz(c.y, i);
      ys = shr_tz(c.x, i);
      if (i < 10) begin
         st = ATAN_STEPS[i];
      end else begin
         st = Z_W'(1) <<< (30 - i);
      end
      if (c.y[XY_W-1]) begin
         r.x = c.x - xs;
         r.y = c.y + ys;
         r.z = c.z - st;
      end else if (c.y != '0) begin
         r.x = c.x + xs;
         r.y = c.y - ys;
         r.z = c.z + st;
      end
      return r;
   endfunction

   function automatic cordic_type root_step(input cordic_type c, input int b);
      cordic_type         r;
      logic [ROOT_W-1:0]  trial;
      logic [RAD_W-1:0]   sq;
      r     = c;
      trial = c.root | (ROOT_W'(1) << b);
      sq    = {{(RAD_W-ROOT_W){1'b0}}, trial} * {{(RAD_W-ROOT_W){1'b0}}, trial};
      if (sq <= c.rad) begin
         r.root = trial;
      end
      return r;
   endfunction

   // sine of whole degrees 0..180 in unsigned Q30, Taylor form in Horner order
   function automatic sin_rom_type build_sin_rom();
      sin_rom_type rom;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] term;
      logic [63:0] part;
      for (int a = 0; a < SIN_ENTRIES; a++) begin
         t = (64'(a) * 64'd314 * ONE_Q30) / 64'd18000;
         if (t > HALF_PI_Q30) begin
            t = PI_Q30 - t;
         end
         t2   = (t * t) >> 30;
         term = ONE_Q30;
         for (int k = 0; k < 5; k++) begin
            part = (t2 * term) >> 30;
            unique case (k)
               0: part = part / 64'd110;
               1: part = part / 64'd72;
               2: part = part / 64'd42;
               3: part = part / 64'd20;
               default: part = part / 64'd6;
            endcase
            term = ONE_Q30 - part;
         end
         rom[a] = 32'((t * term) >> 30);
      end
      return rom;
   endfunction

   localparam sin_rom_type SIN_ROM = build_sin_rom();

endpackage

/* hw/rtl/twojm_cordic.sv */
// Pipelined CORDIC vectoring unit with an integer square root riding alongside.
// Depends on twojm_pkg for the stage record and the step functions.
`timescale 1ns / 1ps

module twojm_cordic (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  twojm_pkg::cordic_type in_stage,
   output twojm_pkg::cordic_type out_stage
);
   import twojm_pkg::*;

   cordic_type stage_ff [CORDIC_STAGES];
   cordic_type stage_in [CORDIC_STAGES];

   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
      always_comb begin
         cordic_type c;
         if (s == 0) begin
            c = in_stage;
         end else begin
            c = stage_ff[s-1];
         end
         for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            if (s * STEPS_PER_STAGE + k < CORDIC_STEPS) begin
               c = cordic_step(c, s * STEPS_PER_STAGE + k);
            end
         end
         // one root bit per stage, most significant first
         if (s < ROOT_W) begin
            c = root_step(c, ROOT_W - 1 - s);
         end
         stage_in[s] = c;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[s].valid <= 1'b0;
         end else if (en) begin
            stage_ff[s].valid <= stage_in[s].valid;
         end
         if (en) begin
            stage_ff[s].x      <= stage_in[s].x;
            stage_ff[s].y      <= stage_in[s].y;
            stage_ff[s].z      <= stage_in[s].z;
            stage_ff[s].rad    <= stage_in[s].rad;
            stage_ff[s].root   <= stage_in[s].root;
            stage_ff[s].neg    <= stage_in[s].neg;
            stage_ff[s].centre <= stage_in[s].centre;
         end
      end
   end

   assign out_stage = stage_ff[CORDIC_STAGES-1];

endmodule

/* hw/rtl/twojm_wheel.sv */
// One wheel back end: angle wrap, sine lookup, scale by drive squared, bias, halve.
// Four register stages; depends on twojm_pkg for widths and the sine table.
`timescale 1ns / 1ps

module twojm_wheel (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic signed [twojm_pkg::HEAD_W-1:0]   offset,
   input  logic signed [twojm_pkg::HEAD_W-1:0]   heading,
   input  logic [twojm_pkg::RAD_W-1:0]           drive_sq,
   input  logic signed [twojm_pkg::BIAS_W-1:0]   bias,
   output logic signed [twojm_pkg::SPEED_W-1:0]  speed
);
   import twojm_pkg::*;

   logic [7:0]                idx_ff,  idx_in;
   logic                      sgn1_ff, sgn1_in;
   logic [RAD_W-1:0]          sq1_ff;
   logic [49:0]               prod_ff, prod_in;
   logic                      sgn2_ff;
   logic [37:0]               quot_ff, quot_in;
   logic                      sgn3_ff;
   logic signed [SPEED_W-1:0] speed_ff, speed_in;

   always_comb begin
      logic signed [HEAD_W:0] a;
      a = (HEAD_W+1)'(offset) - (HEAD_W+1)'(heading);
      if (a > 11'sd180) begin
         a = a - 11'sd360;
      end
      if (a < -11'sd180) begin
         a = a + 11'sd360;
      end
      sgn1_in = a[HEAD_W];
      idx_in  = sgn1_in ? 8'(-a) : 8'(a);
   end

   assign prod_in = {18'd0, SIN_ROM[idx_ff]} * {32'd0, sq1_ff};
   assign quot_in = {20'd0, prod_ff[47:30]} * {18'd0, RECIP_100};

   always_comb begin
      logic [10:0]        mag;
      logic signed [12:0] raw;
      mag = quot_ff[RECIP_100_SH+10:RECIP_100_SH];
      if (sgn3_ff) begin
         raw = 13'(bias) + $signed({2'b00, mag});
      end else begin
         raw = 13'(bias) - $signed({2'b00, mag});
      end
      // halve, rounding toward zero
      raw      = (raw + $signed({12'd0, raw[12]})) >>> 1;
      speed_in = SPEED_W'(raw);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         idx_ff   <= idx_in;
         sgn1_ff  <= sgn1_in;
         sq1_ff   <= drive_sq;
         prod_ff  <= prod_in;
         sgn2_ff  <= sgn1_ff;
         quot_ff  <= quot_in;
         sgn3_ff  <= sgn2_ff;
         speed_ff <= speed_in;
      end
   end

   assign speed = speed_ff;

endmodule

/* hw/rtl/three_wheel_omni_joystick_mixer_core.sv */
// Top level of the three-wheel omni joystick mixer: entry stage, heading stages,
// CORDIC pipeline and three wheel back ends. Depends on twojm_pkg, twojm_cordic, twojm_wheel.
//
//   channel   ports                                   direction
//   request   req_valid req_ready req_point_x/y       in
//   response  rsp_valid rsp_ready rsp_*_speed         out
//   csr       csr_write_enable csr_write_data         in (rotation bias)
//
// One request per cycle while the response is not stalled; the 31 CORDIC steps are
// taken two per stage. Reset clears the valid bits and the bias.
// A stalled response freezes every stage at once, so nothing is lost or repeated;
// req_ready is high whenever the output register is empty or being taken.
`timescale 1ns / 1ps

module three_wheel_omni_joystick_mixer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [7:0]                            req_point_x,
   input  logic [7:0]                            req_point_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [twojm_pkg::SPEED_W-1:0]  rsp_left_speed,
   output logic signed [twojm_pkg::SPEED_W-1:0]  rsp_right_speed,
   output logic signed [twojm_pkg::SPEED_W-1:0]  rsp_back_speed,
   input  logic                                  csr_write_enable,
   input  logic signed [twojm_pkg::BIAS_W-1:0]   csr_write_data
);
   import twojm_pkg::*;

   logic                     en;
   logic signed [BIAS_W-1:0] bias_ff;
   cordic_type               entry_ff, entry_in;
   cordic_type               cordic_out;

   logic        h1_valid_ff, h2_valid_ff, h3_valid_ff;
   logic [46:0] h1_w_ff, h1_w_in;
   logic        h1_pos_ff, h1_neg_ff, h1_centre_ff;
   logic [ROOT_W-1:0] h1_root_ff;
   logic [36:0] h2_prod_ff, h2_prod_in;
   logic        h2_pos_ff, h2_neg_ff, h2_centre_ff;
   logic [RAD_W-1:0] h2_sq_ff, h2_sq_in;
   logic signed [HEAD_W-1:0] h3_heading_ff, h3_heading_in;
   logic [RAD_W-1:0] h3_sq_ff;
   logic [3:0]  wv_ff;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = wv_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
      end else if (csr_write_enable) begin
         bias_ff <= csr_write_data;
      end
   end

   // entry: center the point, fold x positive, form 4 * r^2
   always_comb begin
      logic signed [HEAD_W-1:0] dx, dy;
      logic [HEAD_W-1:0]        adx, ady;
      logic [19:0]              sx, sy, rsum;
      logic signed [39:0]       dy_q;
      dx   = $signed({2'b00, req_point_x}) - CENTRE;
      dy   = CENTRE - $signed({2'b00, req_point_y});
      adx  = dx[HEAD_W-1] ? HEAD_W'(-dx) : HEAD_W'(dx);
      ady  = dy[HEAD_W-1] ? HEAD_W'(-dy) : HEAD_W'(dy);
      sx   = {10'd0, adx} * {10'd0, adx};
      sy   = {10'd0, ady} * {10'd0, ady};
      rsum = (sx + sy) << 2;
      dy_q = {dy, 30'd0};
      entry_in.valid  = req_valid;
      entry_in.x      = $signed({1'b0, adx, 30'd0});
      entry_in.y      = XY_W'(dy_q);
      entry_in.z      = '0;
      entry_in.rad    = RAD_W'(rsum);
      entry_in.root   = '0;
      entry_in.neg    = dx[HEAD_W-1] || (dx == '0);
      entry_in.centre = (dx == '0) && (dy == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (en) begin
         entry_ff.valid <= entry_in.valid;
      end
      if (en) begin
         entry_ff.x      <= entry_in.x;
         entry_ff.y      <= entry_in.y;
         entry_ff.z      <= entry_in.z;
         entry_ff.rad    <= entry_in.rad;
         entry_ff.root   <= entry_in.root;
         entry_ff.neg    <= entry_in.neg;
         entry_ff.centre <= entry_in.centre;
      end
   end

   twojm_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_stage  (entry_ff),
      .out_stage (cordic_out)
   );

   // angle to degrees: |z| * 57294, then divide by 1000 * 2^30
   always_comb begin
      logic [Z_W-2:0] zabs;
      zabs    = cordic_out.z[Z_W-1] ? (Z_W-1)'(-cordic_out.z) : (Z_W-1)'(cordic_out.z);
      h1_w_in = {16'd0, zabs} * {31'd0, HEAD_SCALE};
   end

   always_comb begin
      logic [47:0] sum;
      sum        = {1'b0, h1_w_ff} + (h1_pos_ff ? HEAD_BIAS : 48'd0);
      h2_prod_in = {19'd0, sum[47:30]} * {18'd0, RECIP_1000};
      h2_sq_in   = {{(RAD_W-ROOT_W){1'b0}}, h1_root_ff} * {{(RAD_W-ROOT_W){1'b0}}, h1_root_ff};
   end

   always_comb begin
      logic [8:0] n;
      logic [8:0] hmag;
      n = h2_prod_ff[RECIP_1000_SH+8:RECIP_1000_SH];
      if (h2_pos_ff) begin
         hmag = (n > HEAD_RIGHT) ? 9'd0 : HEAD_RIGHT - n;
      end else begin
         hmag = HEAD_RIGHT + n;
      end
      if (h2_centre_ff) begin
         hmag = '0;
      end
      h3_heading_in = h2_neg_ff ? -$signed({1'b0, hmag}) : $signed({1'b0, hmag});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h1_valid_ff <= 1'b0;
         h2_valid_ff <= 1'b0;
         h3_valid_ff <= 1'b0;
         wv_ff       <= '0;
      end else if (en) begin
         h1_valid_ff <= cordic_out.valid;
         h2_valid_ff <= h1_valid_ff;
         h3_valid_ff <= h2_valid_ff;
         wv_ff       <= {wv_ff[2:0], h3_valid_ff};
      end
      if (en) begin
         h1_w_ff       <= h1_w_in;
         h1_pos_ff     <= !cordic_out.z[Z_W-1];
         h1_neg_ff     <= cordic_out.neg;
         h1_centre_ff  <= cordic_out.centre;
         h1_root_ff    <= cordic_out.root;
         h2_prod_ff    <= h2_prod_in;
         h2_pos_ff     <= h1_pos_ff;
         h2_neg_ff     <= h1_neg_ff;
         h2_centre_ff  <= h1_centre_ff;
         h2_sq_ff      <= h2_sq_in;
         h3_heading_ff <= h3_heading_in;
         h3_sq_ff      <= h2_sq_ff;
      end
   end

   twojm_wheel u_left (
      .clock (clock), .en (en), .offset (OFFSET_LEFT), .heading (h3_heading_ff),
      .drive_sq (h3_sq_ff), .bias (bias_ff), .speed (rsp_left_speed)
   );

   twojm_wheel u_right (
      .clock (clock), .en (en), .offset (OFFSET_RIGHT), .heading (h3_heading_ff),
      .drive_sq (h3_sq_ff), .bias (bias_ff), .speed (rsp_right_speed)
   );

   twojm_wheel u_back (
      .clock (clock), .en (en), .offset (OFFSET_BACK), .heading (h3_heading_ff),
      .drive_sq (h3_sq_ff), .bias (bias_ff), .speed (rsp_back_speed)
   );

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      h3_valid_ff |-> (h3_heading_ff <= 10'sd180) && (h3_heading_ff >= -10'sd180))
      else $error("heading out of range");

   a_centre_heading: assert property (@(posedge clock) disable iff (reset)
      (en && h2_valid_ff && h2_centre_ff) |=> (h3_heading_ff == '0))
      else $error("centre point gave a nonzero heading");

   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_speed <= 12'sd1352) && (rsp_left_speed >= -12'sd1352)
                 && (rsp_right_speed <= 12'sd1352) && (rsp_right_speed >= -12'sd1352)
                 && (rsp_back_speed <= 12'sd1352) && (rsp_back_speed >= -12'sd1352))
      else $error("wheel speed out of range");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> (h3_valid_ff == $past(h3_valid_ff)) && $stable(h3_heading_ff))
      else $error("heading stage moved during a stall");

endmodule

/* tb/tb_top.sv */
// Self-checking bench for three_wheel_omni_joystick_mixer_core: random and directed joystick
// points, an in-bench fixed-point mixer predictor, rotation bias swept between phases.
// Depends on twojm_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
   import twojm_pkg::*;

   localparam int LATENCY   = 24;
   localparam int MAX_CYCLE = 400000;
   localparam int CENTER_PX = 110;

   typedef struct {
      logic [7:0] x;
      logic [7:0] y;
   } point_type;

   typedef struct {
      logic signed [SPEED_W-1:0] left;
      logic signed [SPEED_W-1:0] right;
      logic signed [SPEED_W-1:0] back;
   } speeds_type;

   logic clock;
   logic reset;
   logic req_valid, req_ready;
   logic [7:0] req_point_x, req_point_y;
   logic rsp_valid, rsp_ready;
   logic signed [SPEED_W-1:0] rsp_left_speed, rsp_right_speed, rsp_back_speed;
   logic csr_write_enable;
   logic signed [BIAS_W-1:0] csr_write_data;

   point_type  point_q[$];
   speeds_type speed_q[$];
   int      bias_now;
   int      err_count;
   int      cycle;
   int      send_gap;
   int      recv_gap;
   int      hold_cycles;
   bit      hold_used;
   bit      long_hold;
   bit      quiet;

   three_wheel_omni_joystick_mixer_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_left_speed(rsp_left_speed), .rsp_right_speed(rsp_right_speed),
      .rsp_back_speed(rsp_back_speed),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic longint trunc_shift(longint v, int s);
      if (v >= 0) return v >>> s;
      return -((-v) >>> s);
   endfunction

   function automatic longint heading_angle(longint y, longint x);
      longint z, step, xs, ys;
      z = 0;
      for (int i = 0; i < 31; i++) begin
         if (i < 10) step = longint'(ATAN_STEPS[i]);
         else step = longint'(1) << (30 - i);
         xs = trunc_shift(y, i);
         ys = trunc_shift(x, i);
         if (y > 0) begin
            x = x + xs; y = y - ys; z += step;
         end else if (y < 0) begin
            x = x - xs; y = y + ys; z -= step;
         end else begin
            break;
         end
      end
      return z;
   endfunction

   function automatic longint unsigned sine_q30(longint unsigned t);
      longint unsigned t2, term;
      int divs[5] = '{110, 72, 42, 20, 6};
      t2 = (t * t) >> 30;
      term = 64'd1 << 30;
      for (int k = 0; k < 5; k++)
         term = (64'd1 << 30) - ((t2 * term) >> 30) / divs[k];
      return (t * term) >> 30;
   endfunction

   function automatic int wheel_speed(int offset, int heading, int drive, int bias);
      int a, mag;
      longint unsigned t, s;
      a = offset - heading;
      if (a > 180) a -= 360;
      if (a < -180) a += 360;
      t = (longint'(a < 0 ? -a : a) * 314 * (64'd1 << 30)) / 18000;
      if (t > HALF_PI_Q30) t = PI_Q30 - t;
      s = sine_q30(t);
      mag = int'((s * longint'(drive) * longint'(drive)) / (100 * (64'd1 << 30)));
      if (a < 0) mag = -mag;
      return (-mag + bias) / 2;
   endfunction

   function automatic speeds_type mix_point(point_type p, int bias);
      speeds_type r;
      int dx, dy, heading, drive, sq;
      longint ang, h;
      dx = int'(p.x) - CENTER_PX;
      dy = CENTER_PX - int'(p.y);
      heading = 0;
      drive = 0;
      if (dx != 0 || dy != 0) begin
         ang = heading_angle(longint'(dy) << 30, longint'(dx < 0 ? -dx : dx) << 30);
         h = (longint'(90) << 30) - (ang * 57294) / 1000;
         if (h < 0) h = 0;
         heading = int'(h >> 30);
         if (dx <= 0) heading = -heading;
         sq = 4 * (dx * dx + dy * dy);
         while ((drive + 1) * (drive + 1) <= sq) drive++;
      end
      r.left  = SPEED_W'(wheel_speed(-60, heading, drive, bias));
      r.right = SPEED_W'(wheel_speed(60, heading, drive, bias));
      r.back  = SPEED_W'(wheel_speed(180, heading, drive, bias));
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      err_count++;
   endtask

   // one LSB of slack for the fixed-point approximation
   function automatic bit close_enough(logic signed [SPEED_W-1:0] a,
                                       logic signed [SPEED_W-1:0] b);
      int d;
      d = int'(a) - int'(b);
      return (d >= -1 && d <= 1);
   endfunction

   // request driver
   always @(posedge clock) begin
      point_type p;
      if (reset) begin
         req_valid <= 0;
         req_point_x <= 0;
         req_point_y <= 0;
         send_gap <= 0;
      end else begin
         if (req_valid && req_ready)
            speed_q.push_back(mix_point('{req_point_x, req_point_y}, bias_now));
         if (req_valid && !req_ready) begin
            // hold the request until taken
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 0;
         end else if (point_q.size() != 0) begin
            p = point_q.pop_front();
            req_valid <= 1;
            req_point_x <= p.x;
            req_point_y <= p.y;
            if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 6);
         end else begin
            req_valid <= 0;
         end
      end
   end

   // long receiver hold, armed once by the stimulus
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles <= 0;
         hold_used <= 0;
      end else if (long_hold && !hold_used) begin
         hold_cycles <= 300;
         hold_used <= 1;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      speeds_type want;
      if (reset) begin
         rsp_ready <= 0;
         recv_gap <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (speed_q.size() == 0) begin
               report_mismatch("unexpected response", 0, 0);
            end else begin
               want = speed_q.pop_front();
               if (!close_enough(rsp_left_speed, want.left))
                  report_mismatch("left", rsp_left_speed, want.left);
               if (!close_enough(rsp_right_speed, want.right))
                  report_mismatch("right", rsp_right_speed, want.right);
               if (!close_enough(rsp_back_speed, want.back))
                  report_mismatch("back", rsp_back_speed, want.back);
            end
         end
         if (hold_cycles > 0) begin
            rsp_ready <= 0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
            if (!quiet && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 6);
         end
      end
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic wait_drained();
      while (point_q.size() != 0 || speed_q.size() != 0 || req_valid) @(posedge clock);
      repeat (LATENCY + 6) @(posedge clock);
   endtask

   task automatic write_bias(int value);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_write_data <= BIAS_W'(value);
      bias_now = value;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic add_point(int x, int y);
      point_q.push_back('{8'(x), 8'(y)});
   endtask

   initial begin
      int biases[6] = '{0, 1023, -1024, 0, -1, 0};
      err_count = 0;
      cycle = 0;
      bias_now = 0;
      quiet = 0;
      long_hold = 0;
      reset = 1;
      csr_write_enable = 0;
      csr_write_data = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      repeat (2) @(posedge clock);

      // center, corners, axis crossings, neighbors of center and three off-axis points
      add_point(110, 110); add_point(0, 0);     add_point(255, 255);
      add_point(0, 255);   add_point(255, 0);   add_point(110, 0);
      add_point(110, 255); add_point(0, 110);   add_point(255, 110);
      add_point(111, 110); add_point(109, 110); add_point(110, 109);
      add_point(110, 111); add_point(111, 111); add_point(109, 109);
      add_point(170, 50);  add_point(50, 170);  add_point(85, 255);
      wait_drained();

      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 3) biases[ph] = $urandom_range(0, 2047) - 1024;
         write_bias(biases[ph]);
         if (ph == 5) quiet = 1;
         if (ph == 2) long_hold = 1;
         for (int n = 0; n < 165; n++) begin
            if ($urandom_range(0, 3) == 0)
               add_point($urandom_range(100, 120), $urandom_range(100, 120));
            else
               add_point($urandom_range(0, 255), $urandom_range(0, 255));
         end
         if (ph < 5) begin
            add_point(110, 110); add_point(255, 0); add_point(0, 255);
         end
         wait_drained();
      end

      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
